// ===== src/luhn_card_number_check_macros.svh =====
// Assertion macros for the luhn checker.
`ifndef LUHN_CARD_NUMBER_CHECK_MACROS_SVH
`define LUHN_CARD_NUMBER_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LUHN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LUHN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/luhn_pkg.sv =====
// Shared constants, types and helper functions for the Luhn card number check.
`default_nettype none

package luhn_pkg;

    localparam int NUM_WIDTH        = 54;
    localparam int BRAND_WIDTH      = 2;
    localparam int COUNT_WIDTH      = 5;
    localparam int SUM_WIDTH        = 8;
    localparam int DIGIT_WIDTH      = 4;
    localparam int MAX_DIGITS_DEF   = 16;
    localparam int DECIMAL_BASE     = 10;
    localparam int BCD_DIGITS       = 17;
    localparam int BCD_WIDTH        = BCD_DIGITS * DIGIT_WIDTH;
    localparam int BITS_PER_STEP    = 4;
    localparam int CONV_STEPS       = (NUM_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int SRC_WIDTH        = CONV_STEPS * BITS_PER_STEP;

    localparam int LEN_AMEX         = 15;
    localparam int LEN_LONG         = 16;
    localparam int LEN_SHORT        = 13;

    localparam logic [BRAND_WIDTH-1:0] BRAND_NONE   = 2'd0;
    localparam logic [BRAND_WIDTH-1:0] BRAND_AMEX   = 2'd1;
    localparam logic [BRAND_WIDTH-1:0] BRAND_MASTER = 2'd2;
    localparam logic [BRAND_WIDTH-1:0] BRAND_VISA   = 2'd3;

    typedef struct packed {
        logic load;
        logic conv;
        logic walk;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
    } status_t;

    // One step of double dabble: BITS_PER_STEP adjust-and-shift passes.
    function automatic logic [BCD_WIDTH-1:0] dabble(
        input logic [BCD_WIDTH-1:0]     bcd_in,
        input logic [BITS_PER_STEP-1:0] bits
    );
        logic [BCD_WIDTH-1:0] bcd;
        int                   s;
        int                   k;
        bcd = bcd_in;
        for (s = BITS_PER_STEP - 1; s >= 0; s--)
        begin
            for (k = 0; k < BCD_DIGITS; k++)
            begin
                if (bcd[k*DIGIT_WIDTH +: DIGIT_WIDTH] >= 4'd5)
                begin
                    bcd[k*DIGIT_WIDTH +: DIGIT_WIDTH] =
                        bcd[k*DIGIT_WIDTH +: DIGIT_WIDTH] + 4'd3;
                end
            end
            bcd = {bcd[BCD_WIDTH-2:0], bits[s]};
        end
        return bcd;
    endfunction

    // Luhn weight of a digit; odd positions are doubled and folded.
    function automatic logic [DIGIT_WIDTH-1:0] luhn_weight(
        input logic [DIGIT_WIDTH-1:0] d,
        input logic                   odd
    );
        logic [DIGIT_WIDTH:0]   dbl;
        logic [DIGIT_WIDTH-1:0] w;
        dbl = {d, 1'b0};
        if (!odd)
        begin
            w = d;
        end
        else if (dbl > 5'd9)
        begin
            w = 4'(dbl - 5'd9);
        end
        else
        begin
            w = dbl[DIGIT_WIDTH-1:0];
        end
        return w;
    endfunction

    function automatic logic [BRAND_WIDTH-1:0] classify(
        input logic [COUNT_WIDTH-1:0] count,
        input logic [DIGIT_WIDTH-1:0] hi,
        input logic [DIGIT_WIDTH-1:0] lo
    );
        logic [BRAND_WIDTH-1:0] b;
        b = BRAND_NONE;
        if (count == COUNT_WIDTH'(LEN_AMEX) && hi == 4'd3 && (lo == 4'd4 || lo == 4'd7))
        begin
            b = BRAND_AMEX;
        end
        else if (count == COUNT_WIDTH'(LEN_LONG) && hi == 4'd5 && lo >= 4'd1 && lo <= 4'd5)
        begin
            b = BRAND_MASTER;
        end
        else if ((count == COUNT_WIDTH'(LEN_SHORT) || count == COUNT_WIDTH'(LEN_LONG))
                 && hi == 4'd4)
        begin
            b = BRAND_VISA;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== src/luhn_ctrl.sv =====
// Sequencer for the Luhn check: load, binary-to-decimal conversion, digit walk, result.
`default_nettype none

module luhn_ctrl #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              card_valid,
    output logic                   card_stall,
    input  wire luhn_pkg::status_t status,
    output luhn_pkg::cmd_t         cmd
);

    localparam int WalkDigits = (MAX_DIGITS < luhn_pkg::BCD_DIGITS) ?
                                MAX_DIGITS : luhn_pkg::BCD_DIGITS;
    localparam int MaxSteps   = (WalkDigits > luhn_pkg::CONV_STEPS) ?
                                WalkDigits : luhn_pkg::CONV_STEPS;
    localparam int StepW      = $clog2(MaxSteps);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_WALK = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [StepW-1:0] cnt_reg;
    logic [StepW-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        card_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                card_stall = 1'b0;
                if (card_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                cnt_next = cnt_reg + StepW'(1);
                if (cnt_reg == StepW'(luhn_pkg::CONV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                cnt_next = cnt_reg + StepW'(1);
                if (cnt_reg == StepW'(WalkDigits - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/luhn_dp.sv =====
// Datapath for the Luhn check: double-dabble converter, digit walk and result register.
`default_nettype none

module luhn_dp #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire luhn_pkg::cmd_t                      cmd,
    output luhn_pkg::status_t                        status,
    input  wire logic [luhn_pkg::NUM_WIDTH-1:0]      card_number,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [luhn_pkg::BRAND_WIDTH-1:0]         brand,
    output logic                                     checksum_ok,
    output logic [luhn_pkg::COUNT_WIDTH-1:0]         digit_count,
    output logic [luhn_pkg::SUM_WIDTH-1:0]           luhn_sum
);

    localparam int WalkDigits = (MAX_DIGITS < luhn_pkg::BCD_DIGITS) ?
                                MAX_DIGITS : luhn_pkg::BCD_DIGITS;
    localparam int PosW       = $clog2(WalkDigits + 1);
    localparam int DW         = luhn_pkg::DIGIT_WIDTH;

    logic [luhn_pkg::SRC_WIDTH-1:0]   src_reg,   src_next;
    logic [luhn_pkg::BCD_WIDTH-1:0]   bcd_reg,   bcd_next;
    logic [PosW-1:0]                  pos_reg,   pos_next;
    logic [PosW-1:0]                  count_reg, count_next;
    logic [luhn_pkg::SUM_WIDTH-1:0]   sum_reg,   sum_next;
    logic [DW-1:0]                    mod_reg,   mod_next;
    logic [DW-1:0]                    hi_reg,    hi_next;
    logic [DW-1:0]                    lo_reg,    lo_next;
    logic [DW-1:0]                    prev_reg,  prev_next;

    logic                             valid_reg, valid_next;
    logic [luhn_pkg::BRAND_WIDTH-1:0] brand_reg, brand_next;
    logic                             ok_reg,    ok_next;
    logic [luhn_pkg::COUNT_WIDTH-1:0] cnt_out_reg, cnt_out_next;
    logic [luhn_pkg::SUM_WIDTH-1:0]   sum_out_reg, sum_out_next;

    logic [DW-1:0] digit;
    logic [DW-1:0] weight;
    logic [DW:0]   mod_sum;
    logic          ok;
    logic          overlength;

    assign digit      = bcd_reg[DW-1:0];
    assign weight     = luhn_pkg::luhn_weight(digit, pos_reg[0]);
    assign mod_sum    = {1'b0, mod_reg} + {1'b0, weight};
    assign ok         = (mod_reg == '0);
    assign overlength = (bcd_reg != '0);

    assign status.slot_free = !valid_reg || !result_stall;

    always_comb
    begin
        src_next   = src_reg;
        bcd_next   = bcd_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        mod_next   = mod_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        prev_next  = prev_reg;
        if (cmd.load)
        begin
            src_next   = luhn_pkg::SRC_WIDTH'(card_number);
            bcd_next   = '0;
            pos_next   = '0;
            count_next = '0;
            sum_next   = '0;
            mod_next   = '0;
            hi_next    = '0;
            lo_next    = '0;
            prev_next  = '0;
        end
        else if (cmd.conv)
        begin
            src_next = {src_reg[luhn_pkg::SRC_WIDTH-luhn_pkg::BITS_PER_STEP-1:0],
                        {luhn_pkg::BITS_PER_STEP{1'b0}}};
            bcd_next = luhn_pkg::dabble(bcd_reg,
                src_reg[luhn_pkg::SRC_WIDTH-1 -: luhn_pkg::BITS_PER_STEP]);
        end
        else if (cmd.walk)
        begin
            bcd_next  = {{DW{1'b0}}, bcd_reg[luhn_pkg::BCD_WIDTH-1:DW]};
            pos_next  = pos_reg + PosW'(1);
            sum_next  = sum_reg + luhn_pkg::SUM_WIDTH'(weight);
            if (mod_sum >= (DW+1)'(luhn_pkg::DECIMAL_BASE))
            begin
                mod_next = DW'(mod_sum - (DW+1)'(luhn_pkg::DECIMAL_BASE));
            end
            else
            begin
                mod_next = mod_sum[DW-1:0];
            end
            prev_next = digit;
            if (digit != '0)
            begin
                count_next = pos_reg + PosW'(1);
                hi_next    = digit;
                lo_next    = prev_reg;
            end
        end
    end

    always_comb
    begin
        valid_next   = valid_reg;
        brand_next   = brand_reg;
        ok_next      = ok_reg;
        cnt_out_next = cnt_out_reg;
        sum_out_next = sum_out_reg;
        if (cmd.emit)
        begin
            valid_next   = 1'b1;
            ok_next      = ok;
            // digits left over: every walked position counts
            cnt_out_next = overlength ? luhn_pkg::COUNT_WIDTH'(WalkDigits) :
                                        luhn_pkg::COUNT_WIDTH'(count_reg);
            sum_out_next = sum_reg;
            brand_next   = (ok && !overlength) ?
                           luhn_pkg::classify(luhn_pkg::COUNT_WIDTH'(count_reg),
                                              hi_reg, lo_reg) :
                           luhn_pkg::BRAND_NONE;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        bcd_reg     <= bcd_next;
        pos_reg     <= pos_next;
        count_reg   <= count_next;
        sum_reg     <= sum_next;
        mod_reg     <= mod_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        prev_reg    <= prev_next;
        brand_reg   <= brand_next;
        ok_reg      <= ok_next;
        cnt_out_reg <= cnt_out_next;
        sum_out_reg <= sum_out_next;
    end

    assign result_valid = valid_reg;
    assign brand        = brand_reg;
    assign checksum_ok  = ok_reg;
    assign digit_count  = cnt_out_reg;
    assign luhn_sum     = sum_out_reg;

endmodule

`default_nettype wire

// ===== src/luhn_card_number_check.sv =====
// Top level of the Luhn card number check: controller plus datapath.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  card    | in        | card_valid / card_stall     | card_number[53:0]
//  result  | out       | result_valid / result_stall | brand, checksum_ok, digit_count, luhn_sum
//
//  After acceptance the sequencer loads, runs 14 double-dabble steps of 4 bits each, walks
//  min(MAX_DIGITS, 17) decimal digits at one decimal digit per cycle, then emits the result.
//  card_stall is low only while the sequencer is idle; a new item waits until the last is emitted.
//  A finished result sits in the output register; a new item is taken while it waits,
//  and the next result is held back only while that register is stalled.
//  rst_n clears the sequencer and result_valid asynchronously.
`default_nettype none

module luhn_card_number_check #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           card_valid,
    output logic                                card_stall,
    input  wire logic [luhn_pkg::NUM_WIDTH-1:0] card_number,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [luhn_pkg::BRAND_WIDTH-1:0]    brand,
    output logic                                checksum_ok,
    output logic [luhn_pkg::COUNT_WIDTH-1:0]    digit_count,
    output logic [luhn_pkg::SUM_WIDTH-1:0]      luhn_sum
);

    luhn_pkg::cmd_t    cmd;
    luhn_pkg::status_t status;

    luhn_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .card_valid (card_valid),
        .card_stall (card_stall),
        .status     (status),
        .cmd        (cmd)
    );

    luhn_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .card_number  (card_number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .brand        (brand),
        .checksum_ok  (checksum_ok),
        .digit_count  (digit_count),
        .luhn_sum     (luhn_sum)
    );

endmodule

`default_nettype wire

// ===== src/luhn_checker.sv =====
// Port-level assertions for the Luhn card number check, bound to the top level.
`default_nettype none
`include "luhn_card_number_check_macros.svh"

module luhn_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             card_valid,
    input wire logic                             card_stall,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire logic [luhn_pkg::BRAND_WIDTH-1:0] brand,
    input wire logic                             checksum_ok,
    input wire logic [luhn_pkg::COUNT_WIDTH-1:0] digit_count
);

    `LUHN_ASSERT_NEXT(a_busy_after_accept, card_valid && !card_stall, card_stall, "accepted item did not make the block busy")
    `LUHN_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(brand) && $stable(digit_count), "stalled result changed")
    `LUHN_ASSERT_SAME(a_brand_needs_ok, result_valid && brand != luhn_pkg::BRAND_NONE, checksum_ok, "brand reported without a good checksum")
    `LUHN_ASSERT_SAME(a_brand_length, result_valid && brand != luhn_pkg::BRAND_NONE, digit_count == luhn_pkg::COUNT_WIDTH'(luhn_pkg::LEN_SHORT) || digit_count == luhn_pkg::COUNT_WIDTH'(luhn_pkg::LEN_AMEX) || digit_count == luhn_pkg::COUNT_WIDTH'(luhn_pkg::LEN_LONG), "brand reported for a length with no brand")

endmodule

bind luhn_card_number_check luhn_checker u_luhn_checker (.*);

`default_nettype wire
